// File: hdl/mcbd_pkg.sv
// ---------------------------------------------------------------------------
// mcbd_pkg: shared constants and types of the mip chain box downsampler
// Sizes of the level and pair-sum storage, register indexes and the
// request bundle that drives the pair-sum memory.
// ---------------------------------------------------------------------------
`default_nettype none

package mcbd_pkg;

   // storage sizing
   localparam int MAX_LEVELS = 8;
   localparam int MAX_WIDTH  = 4096;
   localparam int LEVEL_CAP  = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;
   localparam int LVL_W      = $clog2(MAX_LEVELS);
   localparam int IDX_W      = $clog2(MAX_WIDTH);
   localparam int OFF_W      = IDX_W + 1;

   // fixed field widths
   localparam int ROW_W      = 12;
   localparam int BW_W       = 13;
   localparam int LC_W       = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 2'd1;

   // four channel pair sums, channel 0 is red
   typedef logic [3:0][SUM_W-1:0] pair_sum_type;

   // pair-sum memory access bundle
   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      pair_sum_type       wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } pair_ram_req_type;

endpackage

`default_nettype wire

// File: hdl/mcbd_pair_ram.sv
// ---------------------------------------------------------------------------
// mcbd_pair_ram: pair-sum row memory
// One write and one read port, registered read data, write data forwarded
// to a read of the same entry in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mcbd_pair_ram (
   input  wire                             clock,
   input  wire mcbd_pkg::pair_ram_req_type ram_req,
   output mcbd_pkg::pair_sum_type          rd_data
);

   mcbd_pkg::pair_sum_type mem [mcbd_pkg::MAX_WIDTH];
   mcbd_pkg::pair_sum_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // read port, held when no read is issued
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         if (ram_req.we && (ram_req.waddr == ram_req.raddr)) begin
            rd_data_ff <= ram_req.wdata;
         end else begin
            rd_data_ff <= mem[ram_req.raddr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/mip_chain_box_downsampler_top.sv
// ---------------------------------------------------------------------------
// mip_chain_box_downsampler_top: streaming 2x2 box-filter mip generator
// Takes level 0 RGBA8 pixels in raster order and emits every pixel of the
// further mip levels, each channel as the rounded mean of a 2x2 block.
// ---------------------------------------------------------------------------
// The block visits one mip level per clock cycle for each accepted pixel
// while the result register has room. A pixel moves up while it completes
// blocks and stops at the first level where it completes none, or at the
// last level that produces results. The next pixel is taken in the cycle
// that finishes the current one. The pair-sum row memory is read as a pixel
// is accepted and as the cascade moves up a level, so its registered data
// is ready for each level visit; a cycle that would emit a result waits
// while the result register is still full. A completed pixel leaves with
// its level, column and row, and run_last marks the last result of one
// input pixel. With a level count of one, pixels pass through and leave
// no trace. The pair-sum memory and the pending left pixels hold no defined
// contents after reset and need no clearing pass. Registers are written
// only while the block is idle (csr_ready is low while a pixel is in
// progress); base_width is clamped to 2..4096 and level_count to 1..8.
// ---------------------------------------------------------------------------
`default_nettype none

module mip_chain_box_downsampler_top (
   input  wire                                 clock,
   input  wire                                 reset,
   // configuration writes
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mcbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mcbd_pkg::BW_W-1:0]           csr_data,
   // level 0 pixels
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [7:0]                          req_red,
   input  wire  [7:0]                          req_green,
   input  wire  [7:0]                          req_blue,
   input  wire  [7:0]                          req_alpha,
   input  wire                                 req_image_start,
   // produced mip pixels
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [2:0]                          rsp_mip_level,
   output logic [10:0]                         rsp_out_col,
   output logic [11:0]                         rsp_out_row,
   output logic [7:0]                          rsp_out_red,
   output logic [7:0]                          rsp_out_green,
   output logic [7:0]                          rsp_out_blue,
   output logic [7:0]                          rsp_out_alpha,
   output logic                                rsp_run_last
);

   localparam int LVL_W = mcbd_pkg::LVL_W;
   localparam int IDX_W = mcbd_pkg::IDX_W;
   localparam int OFF_W = mcbd_pkg::OFF_W;
   localparam int ROW_W = mcbd_pkg::ROW_W;
   localparam int BW_W  = mcbd_pkg::BW_W;
   localparam int LC_W  = mcbd_pkg::LC_W;
   localparam int SUM_W = mcbd_pkg::SUM_W;

   // configuration
   logic [BW_W-1:0]   base_width_ff;
   logic [LC_W-1:0]   level_count_ff;

   // per level state
   logic [IDX_W-1:0]  col_ff [mcbd_pkg::MAX_LEVELS];
   logic [ROW_W-1:0]  row_ff [mcbd_pkg::MAX_LEVELS];
   logic [3:0][7:0]   pend_ff [mcbd_pkg::MAX_LEVELS];

   // cascade control
   logic              busy_ff;
   logic [LVL_W-1:0]  lv_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [3:0][7:0]   px_ff;

   // result register
   logic              rsp_valid_ff;
   logic [2:0]        rsp_level_ff;
   logic [10:0]       rsp_col_ff;
   logic [11:0]       rsp_row_ff;
   logic [3:0][7:0]   rsp_px_ff;
   logic              rsp_last_ff;

   // level step signals
   logic [BW_W-1:0]   width_eff;
   logic [LC_W-1:0]   levels_eff;
   logic [BW_W-1:0]   w_lv;
   logic [BW_W-1:0]   half_w;
   logic [IDX_W-1:0]  c_cur;
   logic [ROW_W-1:0]  r_cur;
   logic              wrap;
   logic [IDX_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_in;
   logic [LVL_W-1:0]  lv_in;
   logic [OFF_W-1:0]  off_in;
   logic [IDX_W-1:0]  idx_cur;
   logic [IDX_W-1:0]  idx_next;
   logic [IDX_W-1:0]  c0_fwd;
   logic              lv_live;
   logic              produce;
   logic              cont;
   logic              next_prod;
   logic              out_free;
   logic              advance;
   logic              done;
   logic              accept;
   mcbd_pkg::pair_sum_type     sum_cur;
   mcbd_pkg::pair_sum_type     rd_sum;
   logic [3:0][7:0]            avg;
   mcbd_pkg::pair_ram_req_type ram_req;

   // effective register values
   always_comb begin
      width_eff = base_width_ff;
      if (base_width_ff < BW_W'(2)) begin
         width_eff = BW_W'(2);
      end else if (base_width_ff > BW_W'(mcbd_pkg::MAX_WIDTH)) begin
         width_eff = BW_W'(mcbd_pkg::MAX_WIDTH);
      end
      levels_eff = level_count_ff;
      if (level_count_ff < LC_W'(1)) begin
         levels_eff = LC_W'(1);
      end else if (level_count_ff > LC_W'(mcbd_pkg::LEVEL_CAP)) begin
         levels_eff = LC_W'(mcbd_pkg::LEVEL_CAP);
      end
   end

   // one level of the cascade
   always_comb begin
      w_lv = width_eff >> lv_ff;
      if (w_lv == '0) begin
         w_lv = BW_W'(1);
      end
      half_w  = w_lv >> 1;
      c_cur   = col_ff[lv_ff];
      r_cur   = row_ff[lv_ff];
      wrap    = ((BW_W'(c_cur) + BW_W'(1)) >= w_lv);
      col_in  = wrap ? '0 : c_cur + IDX_W'(1);
      row_in  = wrap ? r_cur + ROW_W'(1) : r_cur;
      lv_in   = lv_ff + LVL_W'(1);
      off_in  = off_ff + OFF_W'(half_w);
      idx_cur = off_ff[IDX_W-1:0] + IDX_W'(c_cur >> 1);
      idx_next = off_in[IDX_W-1:0] + IDX_W'(col_ff[lv_in] >> 1);
      // only levels below the top one take part
      lv_live = ((LC_W'(lv_ff) + LC_W'(1)) < levels_eff);
      produce = lv_live && c_cur[0] && r_cur[0];
      cont    = ((LC_W'(lv_ff) + LC_W'(2)) < levels_eff);
      next_prod = cont && col_ff[lv_in][0] && row_ff[lv_in][0];
      for (int ch = 0; ch < 4; ch++) begin
         sum_cur[ch] = SUM_W'(pend_ff[lv_ff][ch]) + SUM_W'(px_ff[ch]);
         avg[ch] = 8'(((SUM_W+2)'(sum_cur[ch]) + (SUM_W+2)'(rd_sum[ch])
                       + (SUM_W+2)'(2)) >> 2);
      end
   end

   // handshake and sequencing
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = busy_ff && (!produce || out_free);
   assign done      = advance && !(produce && cont);
   assign req_ready = !busy_ff || done;
   assign accept    = req_valid && req_ready;
   assign csr_ready = !busy_ff;

   // level 0 column as the next pixel will see it
   always_comb begin
      c0_fwd = col_ff[0];
      if (req_image_start) begin
         c0_fwd = '0;
      end else if (busy_ff && (lv_ff == '0) && lv_live) begin
         c0_fwd = col_in;
      end
   end

   // pair-sum memory access
   always_comb begin
      ram_req.we    = advance && lv_live && c_cur[0] && !r_cur[0];
      ram_req.waddr = idx_cur;
      ram_req.wdata = sum_cur;
      ram_req.re    = accept || (advance && produce && cont);
      ram_req.raddr = accept ? IDX_W'(c0_fwd >> 1) : idx_next;
   end

   mcbd_pair_ram u_pair_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_sum)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff  <= BW_W'(256);
         level_count_ff <= LC_W'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mcbd_pkg::CSR_BASE_WIDTH:  base_width_ff  <= csr_data;
            mcbd_pkg::CSR_LEVEL_COUNT: level_count_ff <= csr_data[LC_W-1:0];
            default: ;
         endcase
      end
   end

   // counters and cascade control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         lv_ff   <= '0;
         off_ff  <= '0;
         for (int l = 0; l < mcbd_pkg::MAX_LEVELS; l++) begin
            col_ff[l] <= '0;
            row_ff[l] <= '0;
         end
      end else begin
         // a new pixel starts at level 0
         if (accept) begin
            busy_ff <= 1'b1;
            lv_ff   <= '0;
            off_ff  <= '0;
         end else begin
            if (done) begin
               busy_ff <= 1'b0;
            end
            if (advance && produce && cont) begin
               lv_ff  <= lv_in;
               off_ff <= off_in;
            end
         end
         // image start clears every counter, else the visited level steps
         for (int l = 0; l < mcbd_pkg::MAX_LEVELS; l++) begin
            if (accept && req_image_start) begin
               col_ff[l] <= '0;
               row_ff[l] <= '0;
            end else if (advance && lv_live && (LVL_W'(l) == lv_ff)) begin
               col_ff[l] <= col_in;
               row_ff[l] <= row_in;
            end
         end
      end
   end

   // pixel being cascaded and pending left pixels
   always_ff @(posedge clock) begin
      if (advance && lv_live && !c_cur[0]) begin
         pend_ff[lv_ff] <= px_ff;
      end
      if (accept) begin
         px_ff <= {req_alpha, req_blue, req_green, req_red};
      end else if (advance && produce) begin
         px_ff <= avg;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_level_ff <= 3'(lv_in);
         rsp_col_ff   <= 11'(c_cur >> 1);
         rsp_row_ff   <= 12'(r_cur >> 1);
         rsp_px_ff    <= avg;
         rsp_last_ff  <= !next_prod;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mip_level = rsp_level_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_red   = rsp_px_ff[0];
   assign rsp_out_green = rsp_px_ff[1];
   assign rsp_out_blue  = rsp_px_ff[2];
   assign rsp_out_alpha = rsp_px_ff[3];
   assign rsp_run_last  = rsp_last_ff;

endmodule

`default_nettype wire

// File: bench/mip_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mip_result_checker: scoreboard for the mip chain box downsampler
// Follows register and pixel beats, keeps its own copy of the per-level
// counters, pending left pixels and pair-sum rows, predicts every produced
// mip pixel in order and compares each result beat field by field.
// ---------------------------------------------------------------------------

module mip_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mcbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcbd_pkg::BW_W-1:0]      csr_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   input  logic [7:0]                     req_alpha,
   input  logic                           req_image_start,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [2:0]                     rsp_mip_level,
   input  logic [10:0]                    rsp_out_col,
   input  logic [11:0]                    rsp_out_row,
   input  logic [7:0]                     rsp_out_red,
   input  logic [7:0]                     rsp_out_green,
   input  logic [7:0]                     rsp_out_blue,
   input  logic [7:0]                     rsp_out_alpha,
   input  logic                           rsp_run_last,
   output int                             mismatch_count,
   output int                             pending_count
);

   typedef struct packed {
      logic [2:0]  level;
      logic [10:0] col;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last;
   } mip_pixel_type;

   // predicted block state, channel 0 is red
   mcbd_pkg::pair_sum_type          pair_sums  [mcbd_pkg::MAX_WIDTH];
   logic [3:0][7:0]                 left_pixel [mcbd_pkg::MAX_LEVELS];
   int unsigned                     col_cnt    [mcbd_pkg::MAX_LEVELS];
   logic [11:0]                     row_cnt    [mcbd_pkg::MAX_LEVELS];
   logic [mcbd_pkg::BW_W-1:0]       width_reg;
   logic [mcbd_pkg::LC_W-1:0]       levels_reg;
   mip_pixel_type                   expected_mips [$];

   function automatic void clear_counters();
      foreach (col_cnt[l]) begin
         col_cnt[l] = 0;
         row_cnt[l] = '0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one level 0 pixel walks up the levels while each visit completes a block
   task automatic cascade_pixel(input logic [3:0][7:0] pixel, input logic start);
      int unsigned            depth;
      int unsigned            span;
      int unsigned            offset;
      int unsigned            w;
      int unsigned            c;
      int unsigned            idx;
      logic [11:0]            r;
      logic [3:0][7:0]        px;
      mcbd_pkg::pair_sum_type sum;
      logic [9:0]             total;
      logic                   made;
      mip_pixel_type          res;
      mip_pixel_type          burst [$];
      if (start) clear_counters();
      px = pixel;
      depth = levels_reg;
      if (depth < 1) depth = 1;
      if (depth > mcbd_pkg::LEVEL_CAP) depth = mcbd_pkg::LEVEL_CAP;
      span = width_reg;
      if (span < 2) span = 2;
      if (span > mcbd_pkg::MAX_WIDTH) span = mcbd_pkg::MAX_WIDTH;
      offset = 0;
      for (int lv = 0; lv + 1 < depth; lv++) begin
         w = span >> lv;
         if (w < 1) w = 1;
         c = col_cnt[lv];
         r = row_cnt[lv];
         made = 1'b0;
         // column advance, wrapping into the next row
         if (c + 1 >= w) begin
            col_cnt[lv] = 0;
            row_cnt[lv] = r + 12'd1;
         end else begin
            col_cnt[lv] = c + 1;
         end
         if (c % 2 == 0) begin
            left_pixel[lv] = px;
         end else begin
            idx = (offset + c / 2) % mcbd_pkg::MAX_WIDTH;
            for (int ch = 0; ch < 4; ch++) begin
               sum[ch] = {1'b0, left_pixel[lv][ch]} + {1'b0, px[ch]};
            end
            if (r[0] == 1'b0) begin
               pair_sums[idx] = sum;
            end else begin
               // lower pair plus stored upper pair, rounded to nearest
               for (int ch = 0; ch < 4; ch++) begin
                  total = {1'b0, sum[ch]} + {1'b0, pair_sums[idx][ch]} + 10'd2;
                  px[ch] = total[9:2];
               end
               res.level = 3'(lv + 1);
               res.col   = 11'(c / 2);
               res.row   = {1'b0, r[11:1]};
               res.red   = px[0];
               res.green = px[1];
               res.blue  = px[2];
               res.alpha = px[3];
               res.last  = 1'b0;
               burst.push_back(res);
               made = 1'b1;
            end
         end
         offset += w / 2;
         if (!made) break;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_mips.push_back(burst[i]);
   endtask

   // beat monitor, sampled at the rising edge
   always @(posedge clock) begin : watch
      mip_pixel_type want;
      if (reset) begin
         clear_counters();
         width_reg  = 13'd256;
         levels_reg = 4'd8;
         expected_mips.delete();
      end else begin
         // register beats
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mcbd_pkg::CSR_BASE_WIDTH:  width_reg = csr_data;
               mcbd_pkg::CSR_LEVEL_COUNT: levels_reg = csr_data[mcbd_pkg::LC_W-1:0];
               default: ;
            endcase
         end
         // result beats against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_mips.size() == 0) begin
               $error("unexpected result beat: level %0d col %0d row %0d",
                      rsp_mip_level, rsp_out_col, rsp_out_row);
               mismatch_count++;
            end else begin
               want = expected_mips.pop_front();
               check_field("mip_level", want.level, rsp_mip_level);
               check_field("out_col", want.col, rsp_out_col);
               check_field("out_row", want.row, rsp_out_row);
               check_field("out_red", want.red, rsp_out_red);
               check_field("out_green", want.green, rsp_out_green);
               check_field("out_blue", want.blue, rsp_out_blue);
               check_field("out_alpha", want.alpha, rsp_out_alpha);
               check_field("run_last", want.last, rsp_run_last);
            end
         end
         // pixel beats
         if (req_valid && req_ready) begin
            cascade_pixel({req_alpha, req_blue, req_green, req_red}, req_image_start);
         end
      end
      pending_count <= expected_mips.size();
   end

endmodule

// File: bench/tb_mip_chain_box_downsampler_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mip_chain_box_downsampler_top: bench for the mip chain box downsampler
// Drives register writes and level 0 pixel beats with random gaps and
// result back-pressure, covering clamped register values, odd and unit
// level widths, image restarts and one deep image that cascades to the top
// level. A separate checker predicts and compares; this module gives the
// verdict.
// ---------------------------------------------------------------------------

module tb_mip_chain_box_downsampler_top;

   localparam logic [mcbd_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // no register behind it
   localparam int RANDOM_PIXELS    = 150;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 16;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int DEEP_SIDE        = 16;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mcbd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mcbd_pkg::BW_W-1:0]      csr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_red = '0;
   logic [7:0]                     req_green = '0;
   logic [7:0]                     req_blue = '0;
   logic [7:0]                     req_alpha = '0;
   logic                           req_image_start = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [2:0]                     rsp_mip_level;
   logic [10:0]                    rsp_out_col;
   logic [11:0]                    rsp_out_row;
   logic [7:0]                     rsp_out_red;
   logic [7:0]                     rsp_out_green;
   logic [7:0]                     rsp_out_blue;
   logic [7:0]                     rsp_out_alpha;
   logic                           rsp_run_last;
   int                             mismatch_count;
   int                             pending_count;

   bit sender_gaps = 1'b1;
   bit rsp_gaps    = 1'b1;
   bit long_hold   = 1'b0;

   mip_chain_box_downsampler_top u_dut (.*);

   mip_result_checker u_checker (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: short random stalls, one long hold-off on request
   initial begin : result_sink
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // overall time limit
   initial begin : watchdog
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one pixel beat, then maybe a sender gap
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic start);
      req_valid       <= 1'b1;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_alpha       <= a;
      req_image_start <= start;
      do @(posedge clock); while (!req_ready);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_random_pixel(input logic start);
      send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(), start);
   endtask

   // both registers back to back, valid held across the beats
   task automatic write_regs(input logic [mcbd_pkg::BW_W-1:0] width_val,
                             input logic [mcbd_pkg::BW_W-1:0] count_val,
                             input bit poke_spare);
      csr_valid <= 1'b1;
      csr_index <= mcbd_pkg::CSR_BASE_WIDTH;
      csr_data  <= width_val;
      do @(posedge clock); while (!csr_ready);
      csr_index <= mcbd_pkg::CSR_LEVEL_COUNT;
      csr_data  <= count_val;
      do @(posedge clock); while (!csr_ready);
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_data  <= mcbd_pkg::BW_W'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // sender waits until every expected pixel is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned span;
      int unsigned rows;
      int unsigned total;
      int unsigned sent;
      int          image_no;
      int          drain_cycles;
      logic [3:0]  depth;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // width 2: level 1 is one pixel wide, so only level 1 results appear
      write_regs(13'd2, 13'd8, 1'b1);
      // results pile up behind a long hold-off and stall the input
      long_hold = 1'b1;
      // saturated block must stay at 255
      for (int i = 0; i < 4; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, i == 0);
      // rounding at the low end, rows keep counting without a restart
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd0, 8'd1, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd1, 8'd1, 8'd1, 8'd2, 1'b0);
      // restart in the middle of a pair
      send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1);
      send_pixel(8'h7F, 8'h80, 8'hFE, 8'h01, 1'b0);
      send_pixel(8'h80, 8'h80, 8'h00, 8'hFF, 1'b0);
      send_pixel(8'h7F, 8'h7F, 8'hFF, 8'h00, 1'b0);
      settle();

      // oversized width and level count clamp to 4096 and 8
      write_regs(13'h1FFF, 13'h1FFF, 1'b0);
      for (int i = 0; i < 6; i++) send_random_pixel(i == 0);
      settle();

      // zero width and level count clamp to 2 and 1: no mip levels at all
      write_regs(13'd0, 13'd0, 1'b0);
      for (int i = 0; i < 4; i++) send_random_pixel(i == 0);

      // random images, mostly well formed, with restarts and truncation
      sent = 0;
      image_no = 0;
      while (sent < RANDOM_PIXELS) begin
         if (image_no == 0 || $urandom_range(0, 2) == 0) begin
            settle();
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                               : (1 << $urandom_range(1, 5));
            depth = ($urandom_range(0, 1) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
            write_regs(mcbd_pkg::BW_W'(span), {9'($urandom), depth},
                       $urandom_range(0, 3) == 0);
         end
         sender_gaps = $urandom_range(0, 4) != 0;
         rsp_gaps    = $urandom_range(0, 4) != 0;
         if (image_no == 2) long_hold = 1'b1;
         if (span < 2) span = 2;
         rows = (span <= 8) ? (1 << $urandom_range(1, 3)) : (1 << $urandom_range(1, 2));
         if ($urandom_range(0, 5) == 0) rows++;
         total = span * rows;
         if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
         for (int p = 0; p < total; p++) begin
            send_random_pixel(p == 0 || $urandom_range(0, 79) == 0);
         end
         sent += total;
         image_no++;
      end

      // deep image without idling: the last pixel cascades through all levels
      settle();
      sender_gaps = 1'b0;
      rsp_gaps    = 1'b0;
      write_regs(13'(DEEP_SIDE), 13'd5, 1'b0);
      for (int p = 0; p < DEEP_SIDE * DEEP_SIDE; p++) send_random_pixel(p == 0);
      req_valid <= 1'b0;

      // drain, then a few more cycles for stray beats
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (pending_count != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_count != 0) $error("%0d expected mip pixels never arrived", pending_count);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
